[design/counting_semaphore_wait_queue_assert.svh]
// Assertion macros for the counting semaphore wait queue.
// Used by the top level; no other dependencies.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CSQ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csq assertion failed");

// Next-cycle implication, checked out of reset.
`define CSQ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csq assertion failed");

`endif

[design/csq_pkg.sv]
// Package for the counting semaphore wait queue: widths, codes and types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package csq_pkg;

  localparam int unsigned WAIT_DEPTH_DEF  = 16;
  localparam int unsigned PRIO_LEVELS_DEF = 64;

  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned TASK_W     = 8;
  localparam int unsigned PRIO_W     = 6;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_START_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ORDER = 8'd1;

  typedef enum logic {
    OP_ACQUIRE = 1'b0,
    OP_RELEASE = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED   = 3'd0,
    ST_REFUSED   = 3'd1,
    ST_QUEUED    = 3'd2,
    ST_FULL      = 3'd3,
    ST_RAISED    = 3'd4,
    ST_HANDED    = 3'd5,
    ST_SATURATED = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FIN
  } state_e;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  typedef struct packed {
    logic               load;
    logic [COUNT_W-1:0] start_count;
    logic               queue_order;
  } cfg_t;

  typedef struct packed {
    logic               busy;
    logic [COUNT_W-1:0] count;
  } stat_t;

endpackage

`default_nettype wire

[design/csq_if.sv]
// Channel interfaces: request, result and configuration write.
// Depends on csq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface csq_req_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [csq_pkg::TASK_W-1:0]  task_id;
  logic [csq_pkg::PRIO_W-1:0]  task_priority;
  logic                        may_wait;

  modport source (output valid, op, task_id, task_priority, may_wait, input ready);
  modport sink   (input valid, op, task_id, task_priority, may_wait, output ready);
endinterface

interface csq_rsp_if #(
  parameter int unsigned WAITERS_W = $clog2(csq_pkg::WAIT_DEPTH_DEF + 1)
);
  logic                          valid;
  logic                          ready;
  logic [csq_pkg::STATUS_W-1:0]  status;
  logic                          woken_valid;
  logic [csq_pkg::TASK_W-1:0]    woken_task;
  logic [csq_pkg::COUNT_W-1:0]   available;
  logic [WAITERS_W-1:0]          waiters;

  modport source (output valid, status, woken_valid, woken_task, available, waiters,
                  input ready);
  modport sink   (input valid, status, woken_valid, woken_task, available, waiters,
                  output ready);
endinterface

interface csq_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [csq_pkg::CFG_IDX_W-1:0]   index;
  logic [csq_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[design/counting_semaphore_wait_queue.sv]
// Counting semaphore with wait list: top level, register decode and checks.
// Depends on csq_pkg, csq_if, csq_core and counting_semaphore_wait_queue_assert.svh.
//
// Usage:
//   req_i  : request beats (op, task_id, task_priority, may_wait).
//   rsp_o  : one result beat per request (status, woken task, count, waiters).
//   cfg_i  : register writes; index 0 reloads the unit count, index 1 picks
//            FIFO (0) or lowest-priority-number (1) hand-off. Always ready.
//   Acquires and releases with an empty list give their result in the cycle
//   after the request beat. A release that hands off reads the wait list RAM one
//   entry a cycle: it scans for a waiter (only the first entry in FIFO order,
//   else every waiter), then moves the entries behind it down by one to close
//   the gap, then posts the result once the output register is free. The wait
//   list RAM has a single read port.
//   One request is worked on at a time. A request is taken only while the
//   block is idle and its output register is empty or drains in that cycle,
//   so a stalled receiver holds off the input once one result waits.
//   Reset clears the count, the wait list length and the hand-off order.
`timescale 1ns / 1ps
`default_nettype none

module counting_semaphore_wait_queue #(
  parameter int unsigned WAIT_DEPTH      = csq_pkg::WAIT_DEPTH_DEF,
  parameter int unsigned PRIORITY_LEVELS = csq_pkg::PRIO_LEVELS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  csq_req_if.sink   req_i,
  csq_rsp_if.source rsp_o,
  csq_cfg_if.sink   cfg_i
);

  logic           order_q, order_d;
  logic           cfg_beat;
  logic           rsp_handed;
  csq_pkg::cfg_t  cfg;
  csq_pkg::stat_t stat;

  assign cfg_i.ready = 1'b1;
  assign cfg_beat    = cfg_i.valid;

  always_comb begin
    order_d = order_q;
    if (cfg_beat && (cfg_i.index == csq_pkg::REG_QUEUE_ORDER)) begin
      order_d = cfg_i.data[0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= 1'b0;
    end else begin
      order_q <= order_d;
    end
  end

  assign cfg = '{
    load:        cfg_beat && (cfg_i.index == csq_pkg::REG_START_COUNT),
    start_count: cfg_i.data[csq_pkg::COUNT_W-1:0],
    queue_order: order_q
  };

  csq_core #(
    .WAIT_DEPTH      (WAIT_DEPTH),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req    (req_i),
    .rsp    (rsp_o),
    .cfg_i  (cfg),
    .stat_o (stat)
  );

  assign rsp_handed = rsp_o.valid && (rsp_o.status == csq_pkg::ST_HANDED);

`include "counting_semaphore_wait_queue_assert.svh"

  `CSQ_ASSERT_IMP(a_waiters_bound, clk_i, rst_ni, rsp_o.valid, 32'(rsp_o.waiters) <= WAIT_DEPTH)
  `CSQ_ASSERT_IMP(a_handed_wakes, clk_i, rst_ni, rsp_handed, rsp_o.woken_valid)
  `CSQ_ASSERT_IMP(a_wake_is_handoff, clk_i, rst_ni, rsp_o.valid && rsp_o.woken_valid, rsp_handed)
  `CSQ_ASSERT_IMP(a_busy_blocks, clk_i, rst_ni, stat.busy, !req_i.ready)
  `CSQ_ASSERT_NXT(a_count_reload, clk_i, rst_ni, cfg.load, stat.count == $past(cfg.start_count))

endmodule

`default_nettype wire

[design/csq_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module csq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[design/csq_core.sv]
// Semaphore sequencer: unit count, waiter count, list scan and compaction.
// Depends on csq_pkg, csq_if and csq_ram.
`timescale 1ns / 1ps
`default_nettype none

module csq_core #(
  parameter int unsigned WAIT_DEPTH      = csq_pkg::WAIT_DEPTH_DEF,
  parameter int unsigned PRIORITY_LEVELS = csq_pkg::PRIO_LEVELS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  csq_req_if.sink            req,
  csq_rsp_if.source          rsp,
  input  wire csq_pkg::cfg_t cfg_i,
  output csq_pkg::stat_t     stat_o
);

  localparam int unsigned AW = $clog2(WAIT_DEPTH);
  localparam int unsigned CW = $clog2(WAIT_DEPTH + 1);
  localparam int unsigned PRIO_MAX = PRIORITY_LEVELS - 1;

  csq_pkg::state_e state_q, state_d;

  logic [csq_pkg::COUNT_W-1:0] count_q, count_d;
  logic [CW-1:0]               total_q, total_d;
  logic [CW-1:0]               scan_n_q, scan_n_d;
  logic [CW-1:0]               iss_q, iss_d;
  logic                        dv_q, dv_d;
  logic [CW-1:0]               di_q, di_d;
  logic [CW-1:0]               best_idx_q, best_idx_d;
  logic [csq_pkg::PRIO_W-1:0]  best_prio_q, best_prio_d;
  logic [csq_pkg::TASK_W-1:0]  best_task_q, best_task_d;
  logic [CW-1:0]               sh_q, sh_d;
  logic                        sv_q, sv_d;
  logic [CW-1:0]               sj_q, sj_d;

  logic                        out_valid_q, out_valid_d;
  csq_pkg::status_e            out_status_q, out_status_d;
  logic                        out_woken_q, out_woken_d;
  logic [csq_pkg::TASK_W-1:0]  out_task_q, out_task_d;
  logic [csq_pkg::COUNT_W-1:0] out_avail_q, out_avail_d;
  logic [CW-1:0]               out_waiters_q, out_waiters_d;

  logic                        req_ready;
  logic                        accept;
  logic                        out_free;
  logic [csq_pkg::PRIO_W-1:0]  prio_c;
  logic                        take;
  logic                        scan_last;
  logic [CW-1:0]               cur_idx;
  logic [csq_pkg::PRIO_W-1:0]  cur_prio;
  logic [csq_pkg::TASK_W-1:0]  cur_task;
  logic [CW-1:0]               shift_waddr;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  csq_pkg::entry_t             ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  csq_pkg::entry_t             ram_rdata;

  csq_ram #(
    .WIDTH ($bits(csq_pkg::entry_t)),
    .DEPTH (WAIT_DEPTH)
  ) u_list (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free  = !out_valid_q || rsp.ready;
  assign req_ready = (state_q == csq_pkg::S_IDLE) && out_free;
  assign accept    = req.valid && req_ready;
  assign req.ready = req_ready;

  assign prio_c = (32'(req.task_priority) >= PRIORITY_LEVELS) ?
                  csq_pkg::PRIO_W'(PRIO_MAX) : req.task_priority;

  // Running minimum; strict compare keeps the oldest on ties.
  assign take      = dv_q && ((di_q == '0) || (ram_rdata.prio < best_prio_q));
  assign cur_idx   = take ? di_q : best_idx_q;
  assign cur_prio  = take ? ram_rdata.prio : best_prio_q;
  assign cur_task  = take ? ram_rdata.task_id : best_task_q;
  assign scan_last = dv_q && (di_q == scan_n_q - CW'(1));

  assign shift_waddr = sj_q - CW'(1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csq_pkg::S_IDLE: begin
        if (accept && (req.op == csq_pkg::OP_RELEASE) && (total_q != '0)) begin
          state_d = csq_pkg::S_SCAN;
        end
      end
      csq_pkg::S_SCAN: begin
        if (scan_last) begin
          state_d = csq_pkg::S_SHIFT;
        end
      end
      csq_pkg::S_SHIFT: begin
        if ((sh_q >= total_q) && !sv_q) begin
          state_d = csq_pkg::S_FIN;
        end
      end
      csq_pkg::S_FIN: begin
        if (out_free) begin
          state_d = csq_pkg::S_IDLE;
        end
      end
      default: state_d = csq_pkg::S_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = total_q[AW-1:0];
    ram_wdata = '{task_id: req.task_id, prio: prio_c};
    ram_re    = 1'b0;
    ram_raddr = iss_q[AW-1:0];
    unique case (state_q)
      csq_pkg::S_IDLE: begin
        ram_we = accept && (req.op == csq_pkg::OP_ACQUIRE) && (count_q == '0) &&
                 req.may_wait && (total_q != CW'(WAIT_DEPTH));
      end
      csq_pkg::S_SCAN: begin
        ram_re = (iss_q < scan_n_q);
      end
      csq_pkg::S_SHIFT: begin
        ram_re    = (sh_q < total_q);
        ram_raddr = sh_q[AW-1:0];
        ram_we    = sv_q;
        ram_waddr = shift_waddr[AW-1:0];
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  // Datapath
  always_comb begin
    count_d       = count_q;
    total_d       = total_q;
    scan_n_d      = scan_n_q;
    iss_d         = iss_q;
    dv_d          = dv_q;
    di_d          = di_q;
    best_idx_d    = best_idx_q;
    best_prio_d   = best_prio_q;
    best_task_d   = best_task_q;
    sh_d          = sh_q;
    sv_d          = sv_q;
    sj_d          = sj_q;
    out_valid_d   = out_valid_q && !rsp.ready;
    out_status_d  = out_status_q;
    out_woken_d   = out_woken_q;
    out_task_d    = out_task_q;
    out_avail_d   = out_avail_q;
    out_waiters_d = out_waiters_q;

    unique case (state_q)
      csq_pkg::S_IDLE: begin
        if (accept) begin
          out_woken_d = 1'b0;
          out_task_d  = '0;
          if (req.op == csq_pkg::OP_ACQUIRE) begin
            out_valid_d = 1'b1;
            priority if (count_q != '0) begin
              count_d      = count_q - csq_pkg::COUNT_W'(1);
              out_status_d = csq_pkg::ST_GRANTED;
            end else if (!req.may_wait) begin
              out_status_d = csq_pkg::ST_REFUSED;
            end else if (total_q == CW'(WAIT_DEPTH)) begin
              out_status_d = csq_pkg::ST_FULL;
            end else begin
              total_d      = total_q + CW'(1);
              out_status_d = csq_pkg::ST_QUEUED;
            end
          end else if (total_q == '0) begin
            out_valid_d = 1'b1;
            if (count_q == '1) begin
              out_status_d = csq_pkg::ST_SATURATED;
            end else begin
              count_d      = count_q + csq_pkg::COUNT_W'(1);
              out_status_d = csq_pkg::ST_RAISED;
            end
          end else begin
            scan_n_d = cfg_i.queue_order ? total_q : CW'(1);
            iss_d    = '0;
            dv_d     = 1'b0;
          end
          out_avail_d   = count_d;
          out_waiters_d = total_d;
        end
      end
      csq_pkg::S_SCAN: begin
        if (iss_q < scan_n_q) begin
          iss_d = iss_q + CW'(1);
          dv_d  = 1'b1;
          di_d  = iss_q;
        end else begin
          dv_d = 1'b0;
        end
        best_idx_d  = cur_idx;
        best_prio_d = cur_prio;
        best_task_d = cur_task;
        if (scan_last) begin
          sh_d = cur_idx + CW'(1);
          sv_d = 1'b0;
        end
      end
      csq_pkg::S_SHIFT: begin
        if (sh_q < total_q) begin
          sh_d = sh_q + CW'(1);
          sv_d = 1'b1;
          sj_d = sh_q;
        end else begin
          sv_d = 1'b0;
        end
      end
      csq_pkg::S_FIN: begin
        if (out_free) begin
          total_d       = total_q - CW'(1);
          out_valid_d   = 1'b1;
          out_status_d  = csq_pkg::ST_HANDED;
          out_woken_d   = 1'b1;
          out_task_d    = best_task_q;
          out_avail_d   = count_q;
          out_waiters_d = total_d;
        end
      end
      default: ;
    endcase

    if (cfg_i.load) begin
      count_d = cfg_i.start_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csq_pkg::S_IDLE;
      count_q     <= '0;
      total_q     <= '0;
      dv_q        <= 1'b0;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      total_q     <= total_d;
      dv_q        <= dv_d;
      sv_q        <= sv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_n_q      <= scan_n_d;
    iss_q         <= iss_d;
    di_q          <= di_d;
    best_idx_q    <= best_idx_d;
    best_prio_q   <= best_prio_d;
    best_task_q   <= best_task_d;
    sh_q          <= sh_d;
    sj_q          <= sj_d;
    out_status_q  <= out_status_d;
    out_woken_q   <= out_woken_d;
    out_task_q    <= out_task_d;
    out_avail_q   <= out_avail_d;
    out_waiters_q <= out_waiters_d;
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_status_q;
  assign rsp.woken_valid = out_woken_q;
  assign rsp.woken_task  = out_task_q;
  assign rsp.available   = out_avail_q;
  assign rsp.waiters     = out_waiters_q;

  assign stat_o = '{busy: (state_q != csq_pkg::S_IDLE), count: count_q};

endmodule

`default_nettype wire

[test/tb_counting_semaphore_wait_queue.sv]
// Testbench for counting_semaphore_wait_queue: directed and random request beats
// checked against an in-bench semaphore and wait-list predictor.
// Depends on csq_pkg, csq_if and the design top level.
`timescale 1ns / 1ps

module tb_counting_semaphore_wait_queue;
  import csq_pkg::*;

  localparam int unsigned WAIT_DEPTH  = WAIT_DEPTH_DEF;
  localparam int          CYCLE_LIMIT = 400000;
  localparam int          HOLD_AT     = 200;
  localparam int          HOLD_LEN    = 400;
  localparam int          DRAIN_WAIT  = 2 * WAIT_DEPTH + 8;
  localparam int          RAND_PHASES = 8;
  localparam int          PHASE_ITEMS = 78;

  typedef struct packed {
    op_e               op;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] prio;
    logic              may_wait;
  } sem_req_t;

  typedef struct packed {
    status_e            status;
    logic               woken_valid;
    logic [TASK_W-1:0]  woken_task;
    logic [COUNT_W-1:0] available;
    logic [4:0]         waiters;
  } sem_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  req_valid = 1'b0;
  logic                  req_op    = 1'b0;
  logic [TASK_W-1:0]     req_task  = '0;
  logic [PRIO_W-1:0]     req_prio  = '0;
  logic                  req_wait  = 1'b0;
  logic                  rsp_ready = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  csq_req_if req ();
  csq_rsp_if rsp ();
  csq_cfg_if cfg ();

  assign req.valid         = req_valid;
  assign req.op            = req_op;
  assign req.task_id       = req_task;
  assign req.task_priority = req_prio;
  assign req.may_wait      = req_wait;
  assign rsp.ready         = rsp_ready;
  assign cfg.valid         = cfg_valid;
  assign cfg.index         = cfg_index;
  assign cfg.data          = cfg_data;

  counting_semaphore_wait_queue DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [COUNT_W-1:0] units;
  logic               by_priority;
  logic [TASK_W-1:0]  wl_task [WAIT_DEPTH];
  logic [PRIO_W-1:0]  wl_prio [WAIT_DEPTH];
  int                 wl_len;

  sem_req_t req_backlog[$];
  sem_rsp_t outcome_q[$];
  sem_req_t cur_item;
  sem_rsp_t want;

  int req_issued;
  int req_beats;
  int req_gap;
  int req_quiet;
  int rsp_gap;
  int rsp_quiet;
  int hold_left;
  bit hold_done;
  int errors;
  int cycle_cnt;
  int settings_used;
  int status_hits [7];

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic apply_request(input sem_req_t r);
    sem_rsp_t res;
    int pick;
    int i;
    res = '0;
    if (r.op == OP_ACQUIRE) begin
      if (units != 0) begin
        units--;
        res.status = ST_GRANTED;
      end else if (!r.may_wait) begin
        res.status = ST_REFUSED;
      end else if (wl_len >= WAIT_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        wl_task[wl_len] = r.task_id;
        wl_prio[wl_len] = r.prio;
        wl_len++;
        res.status = ST_QUEUED;
      end
    end else if (wl_len == 0) begin
      if (units == '1) begin
        res.status = ST_SATURATED;
      end else begin
        units++;
        res.status = ST_RAISED;
      end
    end else begin
      pick = 0;
      if (by_priority) begin
        for (i = 1; i < wl_len; i++) begin
          if (wl_prio[i] < wl_prio[pick]) pick = i;
        end
      end
      res.status      = ST_HANDED;
      res.woken_valid = 1'b1;
      res.woken_task  = wl_task[pick];
      for (i = pick; i + 1 < wl_len; i++) begin
        wl_task[i] = wl_task[i+1];
        wl_prio[i] = wl_prio[i+1];
      end
      wl_len--;
    end
    res.available = units;
    res.waiters   = 5'(wl_len);
    outcome_q.push_back(res);
  endtask

  task automatic push_item(input op_e op, input logic [TASK_W-1:0] id,
                           input logic [PRIO_W-1:0] prio, input logic may_wait);
    sem_req_t it;
    it.op       = op;
    it.task_id  = id;
    it.prio     = prio;
    it.may_wait = may_wait;
    req_backlog.push_back(it);
    req_issued++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg_valid <= 1'b0;
    if (idx == REG_START_COUNT) begin
      units = val;
    end else if (idx == REG_QUEUE_ORDER) begin
      by_priority = val[0];
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk_i); while (req_beats != req_issued || outcome_q.size() != 0);
    repeat (4) @(posedge clk_i);
    settings_used++;
  endtask

  // request driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req.ready) begin
        apply_request(cur_item);
        req_beats++;
      end
      if (!req_valid || req.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() > 0) begin
          cur_item = req_backlog.pop_front();
          req_op    <= cur_item.op;
          req_task  <= cur_item.task_id;
          req_prio  <= cur_item.prio;
          req_wait  <= cur_item.may_wait;
          req_valid <= 1'b1;
          if (req_quiet > 0) begin
            req_quiet--;
            req_gap = 0;
          end else begin
            req_gap = draw_gap();
            if ($urandom_range(0, 49) == 0) req_quiet = $urandom_range(20, 60);
          end
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // long result back-pressure so the block fills and stalls its input
  always @(posedge clk_i) begin
    if (!hold_done && req_beats >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left <= HOLD_LEN;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp.valid && rsp_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result beat with nothing expected: status %0d", rsp.status);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          status_hits[want.status]++;
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            errors++;
          end
          if (rsp.woken_valid !== want.woken_valid) begin
            $error("woken_valid: expected %0d, got %0d", want.woken_valid, rsp.woken_valid);
            errors++;
          end
          if (rsp.woken_task !== want.woken_task) begin
            $error("woken_task: expected %0d, got %0d", want.woken_task, rsp.woken_task);
            errors++;
          end
          if (rsp.available !== want.available) begin
            $error("available: expected %0d, got %0d", want.available, rsp.available);
            errors++;
          end
          if (rsp.waiters !== want.waiters) begin
            $error("waiters: expected %0d, got %0d", want.waiters, rsp.waiters);
            errors++;
          end
        end
        if (rsp_quiet > 0) begin
          rsp_quiet--;
          rsp_gap = 0;
        end else begin
          rsp_gap = draw_gap();
          if ($urandom_range(0, 49) == 0) rsp_quiet = $urandom_range(20, 60);
        end
      end else if (rsp_gap > 0) begin
        rsp_gap--;
      end
      rsp_ready <= (rsp_gap == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt, outcome_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int acq_pct;
    sem_req_t it;
    units       = '0;
    by_priority = 1'b0;
    wl_len      = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: empty count, FIFO order
    push_item(OP_ACQUIRE, 8'd0, 6'd0, 1'b0);
    push_item(OP_RELEASE, 8'hFF, 6'h3F, 1'b1);
    push_item(OP_ACQUIRE, 8'h5A, 6'h15, 1'b1);
    push_item(OP_ACQUIRE, 8'hA5, 6'h2A, 1'b0);
    wait_idle();

    // count at maximum
    write_reg(REG_START_COUNT, 16'hFFFF);
    push_item(OP_RELEASE, 8'h00, 6'h00, 1'b0);
    push_item(OP_ACQUIRE, 8'h01, 6'h01, 1'b0);
    push_item(OP_RELEASE, 8'h02, 6'h02, 1'b1);
    push_item(OP_RELEASE, 8'h03, 6'h03, 1'b1);
    wait_idle();

    // fill the wait list, overflow it, hand off in FIFO order
    write_reg(REG_START_COUNT, 16'h0000);
    for (int i = 0; i < WAIT_DEPTH; i++) begin
      push_item(OP_ACQUIRE, 8'(i * 17), (i % 4 == 1) ? 6'd0 : 6'(63 - i), 1'b1);
    end
    push_item(OP_ACQUIRE, 8'hAA, 6'h2A, 1'b1);
    push_item(OP_RELEASE, 8'h55, 6'h15, 1'b0);
    wait_idle();

    // priority order, ignored indexes, reload with waiters present
    write_reg(REG_QUEUE_ORDER, 16'h0001);
    write_reg(8'd2, 16'hFFFF);
    write_reg(8'hFF, 16'h0000);
    write_reg(REG_START_COUNT, 16'd3);
    push_item(OP_ACQUIRE, 8'h77, 6'h3F, 1'b1);
    push_item(OP_RELEASE, 8'h00, 6'h00, 1'b0);
    push_item(OP_RELEASE, 8'hFF, 6'h3F, 1'b1);
    push_item(OP_RELEASE, 8'h10, 6'h20, 1'b0);
    wait_idle();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph % 2 == 0) begin
        write_reg(REG_QUEUE_ORDER, 16'($urandom_range(0, 1)));
      end
      case ($urandom_range(0, 6))
        0, 1:    write_reg(REG_START_COUNT, 16'd0);
        2:       write_reg(REG_START_COUNT, 16'd1);
        3:       write_reg(REG_START_COUNT, 16'($urandom_range(2, 6)));
        4:       write_reg(REG_START_COUNT, 16'hFFFE);
        5:       write_reg(REG_START_COUNT, 16'hFFFF);
        default: write_reg(REG_START_COUNT, 16'($urandom_range(0, 65535)));
      endcase
      if (ph % 2 == 1) begin
        write_reg(REG_QUEUE_ORDER, 16'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(8'($urandom_range(2, 255)), 16'($urandom_range(0, 65535)));
      end
      case ($urandom_range(0, 2))
        0:       acq_pct = 35;
        1:       acq_pct = 55;
        default: acq_pct = 80;
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        it.op       = ($urandom_range(0, 99) < acq_pct) ? OP_ACQUIRE : OP_RELEASE;
        it.task_id  = 8'($urandom_range(0, 255));
        it.prio     = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 3))
                                                  : 6'($urandom_range(0, 63));
        it.may_wait = ($urandom_range(0, 9) != 0);
        push_item(it.op, it.task_id, it.prio, it.may_wait);
      end
      wait_idle();
    end

    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (outcome_q.size() != 0) begin
      $error("%0d expected results never arrived", outcome_q.size());
      errors++;
    end
    $display("covered %0d request beats over %0d settings, %0d cycles", req_beats,
             settings_used, cycle_cnt);
    $display("granted %0d refused %0d queued %0d full %0d raised %0d handed %0d saturated %0d",
             status_hits[ST_GRANTED], status_hits[ST_REFUSED], status_hits[ST_QUEUED],
             status_hits[ST_FULL], status_hits[ST_RAISED], status_hits[ST_HANDED],
             status_hits[ST_SATURATED]);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
